// ===== src/cmrq_pkg.sv =====
// -----------------------------------------------------------------------------
// cmrq_pkg
// Shared types, codes and helpers of the checksummed message ring queue.
// -----------------------------------------------------------------------------
package cmrq_pkg;

   // request commands
   localparam logic [1:0] CMD_BEGIN    = 2'd0;
   localparam logic [1:0] CMD_PAYLOAD  = 2'd1;
   localparam logic [1:0] CMD_POP      = 2'd2;
   localparam logic [1:0] CMD_RESERVED = 2'd3;

   // response status codes
   localparam logic [2:0] ST_BEGUN     = 3'd0;
   localparam logic [2:0] ST_NO_ROOM   = 3'd1;
   localparam logic [2:0] ST_STORED    = 3'd2;
   localparam logic [2:0] ST_IGNORED   = 3'd3;
   localparam logic [2:0] ST_EMPTY     = 3'd4;
   localparam logic [2:0] ST_BYTE      = 3'd5;
   localparam logic [2:0] ST_EMPTY_MSG = 3'd6;

   // datapath operations
   localparam logic [3:0] OP_NOP      = 4'd0;
   localparam logic [3:0] OP_LATCH    = 4'd1;
   localparam logic [3:0] OP_BEGIN    = 4'd2;
   localparam logic [3:0] OP_HDR_WR   = 4'd3;
   localparam logic [3:0] OP_PAY_WR   = 4'd4;
   localparam logic [3:0] OP_HASH_WR  = 4'd5;
   localparam logic [3:0] OP_HDR_RD   = 4'd6;
   localparam logic [3:0] OP_HDR_DONE = 4'd7;
   localparam logic [3:0] OP_BYTE_RD  = 4'd8;
   localparam logic [3:0] OP_BYTE_CAP = 4'd9;
   localparam logic [3:0] OP_RESPOND  = 4'd10;

   localparam logic [10:0] COUNT_MAX    = 11'h7FF;
   localparam logic [8:0]  MAX_LENGTH   = 9'd256;
   localparam logic [7:0]  LONG_MARKER  = 8'd128;
   localparam logic [9:0]  HASH_MODULUS = 10'd510;

   typedef struct packed {
      logic [3:0] op;
      logic [1:0] idx;
      logic       cap;
      logic [2:0] code;
   } cmrq_ctl_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic       len_ok;
      logic       writing_open;
      logic       reading_open;
      logic       empty;
      logic       count_max;
      logic       room_ok;
      logic       wrem_one;
      logic       out_free;
   } cmrq_stat_type;

   // running sum modulo 510
   function automatic logic [8:0] mod_add(input logic [8:0] s, input logic [7:0] b);
      logic [9:0] t;
      t = {1'b0, s} + {2'b00, b};
      if (t >= HASH_MODULUS) t = t - HASH_MODULUS;
      return t[8:0];
   endfunction

   // two-byte hash of a reduced sum
   function automatic logic [15:0] hash_of(input logic [8:0] s);
      logic [8:0] d;
      d = s - 9'd255;
      if (s > 9'd255) return {8'hFF, d[7:0]};
      return {s[7:0], 8'h00};
   endfunction

endpackage

// ===== src/cmrq_if.sv =====
// -----------------------------------------------------------------------------
// cmrq_if
// Request and response channel interfaces, valid/ready handshake.
// -----------------------------------------------------------------------------
interface cmrq_req_if;
   import cmrq_pkg::*;
   logic       valid;
   logic       ready;
   logic [1:0] cmd;
   logic [8:0] msg_length;
   logic [7:0] data_byte;
   modport source (output valid, cmd, msg_length, data_byte, input ready);
   modport sink (input valid, cmd, msg_length, data_byte, output ready);
endinterface

interface cmrq_rsp_if;
   import cmrq_pkg::*;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [7:0]  data_out;
   logic        last_byte;
   logic        checksum_error;
   logic [10:0] queued_messages;
   modport source (output valid, status, data_out, last_byte, checksum_error,
                   queued_messages, input ready);
   modport sink (input valid, status, data_out, last_byte, checksum_error,
                 queued_messages, output ready);
endinterface

// ===== src/checksummed_message_ring_queue_core.sv =====
// Throughput: one request at a time; the single-port byte store takes one
// access per cycle, which sets the header and hash sequences.
// Reset: synchronous, active high; clears pointers, counters and handshakes.
// The byte store is not cleared.
// -----------------------------------------------------------------------------
// checksummed_message_ring_queue_core
// Byte ring queue of framed, hashed messages with a controller and datapath.
// -----------------------------------------------------------------------------
module checksummed_message_ring_queue_core #(
   parameter int BUFFER_BYTES = 4096
) (
   input  logic       clock,
   input  logic       reset,
   cmrq_req_if.sink   req,
   cmrq_rsp_if.source rsp
);
   import cmrq_pkg::*;

   cmrq_ctl_type  ctl;
   cmrq_stat_type st;

   cmrq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .st        (st),
      .ctl       (ctl)
   );

   cmrq_dp #(.BUFFER_BYTES(BUFFER_BYTES)) u_dp (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .st    (st),
      .req   (req),
      .rsp   (rsp)
   );

`ifndef ASSERT_OFF
   // one request in flight at a time
   a_one_request: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready |=> !req.ready) else $error("second request accepted");

   // last flag only on a popped byte or an empty message
   a_last_kind: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.last_byte |-> rsp.status == ST_BYTE || rsp.status == ST_EMPTY_MSG)
      else $error("last flag on wrong status");

   // hash error only on the last pop result
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.checksum_error |-> rsp.last_byte) else $error("stray hash error");
`endif
endmodule

// ===== src/cmrq_ram.sv =====
// -----------------------------------------------------------------------------
// cmrq_ram
// Generic single-port RAM with registered read data.
// -----------------------------------------------------------------------------
module cmrq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port and registered read
   always_ff @(posedge clock) begin
      if (we) mem[addr] <= wdata;
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;
endmodule

// ===== src/cmrq_dp.sv =====
// -----------------------------------------------------------------------------
// cmrq_dp
// Datapath: pointers, counters, running hashes, byte store and response reg.
// -----------------------------------------------------------------------------
module cmrq_dp #(
   parameter int BUFFER_BYTES = 4096
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cmrq_pkg::cmrq_ctl_type ctl,
   output cmrq_pkg::cmrq_stat_type st,
   cmrq_req_if.sink              req,
   cmrq_rsp_if.source            rsp
);
   import cmrq_pkg::*;

   localparam int AW = $clog2(BUFFER_BYTES);
   localparam int PW = $clog2(BUFFER_BYTES + 1);
   localparam logic [PW:0] BUF_END = (PW + 1)'(BUFFER_BYTES);

   logic [1:0]    cmd_ff, cmd_in;
   logic [8:0]    len_ff, len_in;
   logic [7:0]    byte_ff, byte_in;
   logic [PW-1:0] wpos_ff, wpos_in, rpos_ff, rpos_in, hpos_ff, hpos_in;
   logic [10:0]   count_ff, count_in;
   logic          wopen_ff, wopen_in, ropen_ff, ropen_in;
   logic [8:0]    wrem_ff, wrem_in, rrem_ff, rrem_in;
   logic [8:0]    wmod_ff, wmod_in, rmod_ff, rmod_in;
   logic [15:0]   hash_ff, hash_in;
   logic [31:0]   hdr_ff, hdr_in;
   logic [7:0]    dout_ff, dout_in;
   logic          last_ff, last_in, err_ff, err_in;
   logic          rvalid_ff, rvalid_in;
   logic [2:0]    rstat_ff, rstat_in;
   logic [7:0]    rdata_ff, rdata_in;
   logic          rlast_ff, rlast_in, rerr_ff, rerr_in;
   logic [10:0]   rqueued_ff, rqueued_in;

   logic          mem_we;
   logic [PW-1:0] mem_pos;
   logic [7:0]    mem_wdata, mem_rdata;
   logic [PW:0]   frame_end, room_limit, wpos_hdr, rpos_hdr, rpos_next;
   logic [8:0]    size, rmod_next;
   logic [15:0]   whash;

   cmrq_ram #(.WIDTH(8), .DEPTH(BUFFER_BYTES)) u_ram (
      .clock (clock),
      .we    (mem_we),
      .addr  (mem_pos[AW-1:0]),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   // room checks against the latched length
   assign frame_end  = {1'b0, wpos_ff} + (PW + 1)'(len_ff) + (PW + 1)'(4);
   assign room_limit = (wpos_ff > rpos_ff) ? BUF_END : {1'b0, rpos_ff};
   assign wpos_hdr   = {1'b0, hpos_ff} + (PW + 1)'(4);
   assign rpos_hdr   = {1'b0, rpos_ff} + (PW + 1)'(4);
   assign rpos_next  = {1'b0, rpos_ff} + (PW + 1)'(1);
   assign size       = (hdr_ff[31:24] == LONG_MARKER) ? MAX_LENGTH : {1'b0, hdr_ff[7:0]};
   assign rmod_next  = mod_add(rmod_ff, mem_rdata);
   assign whash      = hash_of(wmod_ff);

   // status toward the controller
   always_comb begin
      st.cmd          = cmd_ff;
      st.len_ok       = (len_ff <= MAX_LENGTH);
      st.writing_open = wopen_ff;
      st.reading_open = ropen_ff;
      st.empty        = (count_ff == 11'd0) && !ropen_ff;
      st.count_max    = (count_ff == COUNT_MAX);
      st.room_ok      = (frame_end <= room_limit);
      st.wrem_one     = (wrem_ff == 9'd1);
      st.out_free     = !rvalid_ff || rsp.ready;
   end

   // byte store address and write data
   always_comb begin
      mem_we    = 1'b0;
      mem_pos   = rpos_ff;
      mem_wdata = 8'd0;
      case (ctl.op)
         OP_HDR_WR: begin
            mem_we  = 1'b1;
            mem_pos = hpos_ff + PW'(ctl.idx);
            case (ctl.idx)
               2'd0:    mem_wdata = (len_ff == MAX_LENGTH) ? LONG_MARKER : 8'd0;
               2'd3:    mem_wdata = len_ff[7:0];
               default: mem_wdata = 8'd0;
            endcase
         end
         OP_PAY_WR: begin
            mem_we    = 1'b1;
            mem_pos   = wpos_ff;
            mem_wdata = byte_ff;
         end
         OP_HASH_WR: begin
            mem_we    = 1'b1;
            mem_pos   = hpos_ff + PW'(ctl.idx);
            mem_wdata = (ctl.idx == 2'd1) ? whash[15:8] : whash[7:0];
         end
         OP_HDR_RD: mem_pos = rpos_ff + PW'(ctl.idx);
         default:   mem_pos = rpos_ff;
      endcase
   end

   // next state of the queue registers
   always_comb begin
      cmd_in = cmd_ff; len_in = len_ff; byte_in = byte_ff;
      wpos_in = wpos_ff; rpos_in = rpos_ff; hpos_in = hpos_ff;
      count_in = count_ff; wopen_in = wopen_ff; ropen_in = ropen_ff;
      wrem_in = wrem_ff; rrem_in = rrem_ff; wmod_in = wmod_ff; rmod_in = rmod_ff;
      hash_in = hash_ff; dout_in = dout_ff; last_in = last_ff; err_in = err_ff;
      hdr_in = ctl.cap ? {hdr_ff[23:0], mem_rdata} : hdr_ff;
      rvalid_in = rvalid_ff && !rsp.ready;
      rstat_in = rstat_ff; rdata_in = rdata_ff; rlast_in = rlast_ff;
      rerr_in = rerr_ff; rqueued_in = rqueued_ff;
      case (ctl.op)
         OP_LATCH: begin
            cmd_in  = req.cmd;
            len_in  = req.msg_length;
            byte_in = req.data_byte;
            dout_in = 8'd0;
            last_in = 1'b0;
            err_in  = 1'b0;
         end
         OP_BEGIN: begin
            // an empty queue restarts at the base when the frame would overrun
            if (st.empty && (frame_end > BUF_END)) begin
               hpos_in = '0;
               rpos_in = '0;
            end else begin
               hpos_in = wpos_ff;
            end
         end
         OP_HDR_WR: begin
            if (ctl.idx == 2'd3) begin
               wmod_in = 9'd0;
               wrem_in = len_ff;
               if (len_ff == 9'd0) begin
                  count_in = count_ff + 11'd1;
                  wpos_in  = (wpos_hdr >= BUF_END) ? '0 : wpos_hdr[PW-1:0];
               end else begin
                  wopen_in = 1'b1;
                  wpos_in  = wpos_hdr[PW-1:0];
               end
            end
         end
         OP_PAY_WR: begin
            wpos_in = wpos_ff + PW'(1);
            wmod_in = mod_add(wmod_ff, byte_ff);
            wrem_in = wrem_ff - 9'd1;
         end
         OP_HASH_WR: begin
            if (ctl.idx == 2'd2) begin
               wopen_in = 1'b0;
               count_in = count_ff + 11'd1;
               if ({1'b0, wpos_ff} >= BUF_END) wpos_in = '0;
            end
         end
         OP_HDR_DONE: begin
            hash_in  = hdr_ff[23:8];
            count_in = count_ff - 11'd1;
            rmod_in  = 9'd0;
            if (size == 9'd0) begin
               rpos_in = (rpos_hdr >= BUF_END) ? '0 : rpos_hdr[PW-1:0];
               last_in = 1'b1;
               err_in  = (hdr_ff[23:8] != hash_of(9'd0));
            end else begin
               rpos_in  = rpos_hdr[PW-1:0];
               rrem_in  = size;
               ropen_in = 1'b1;
            end
         end
         OP_BYTE_CAP: begin
            dout_in = mem_rdata;
            rmod_in = rmod_next;
            rrem_in = rrem_ff - 9'd1;
            rpos_in = rpos_next[PW-1:0];
            if (rrem_ff == 9'd1) begin
               ropen_in = 1'b0;
               last_in  = 1'b1;
               err_in   = (hash_ff != hash_of(rmod_next));
               if (rpos_next >= BUF_END) rpos_in = '0;
            end
         end
         OP_RESPOND: begin
            rvalid_in  = 1'b1;
            rstat_in   = ctl.code;
            rdata_in   = dout_ff;
            rlast_in   = last_ff;
            rerr_in    = err_ff;
            rqueued_in = count_ff;
         end
         default: begin
            rvalid_in = rvalid_ff && !rsp.ready;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wpos_ff   <= '0;
         rpos_ff   <= '0;
         hpos_ff   <= '0;
         count_ff  <= '0;
         wopen_ff  <= 1'b0;
         ropen_ff  <= 1'b0;
         wrem_ff   <= '0;
         rrem_ff   <= '0;
         wmod_ff   <= '0;
         rmod_ff   <= '0;
         hash_ff   <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         wpos_ff   <= wpos_in;
         rpos_ff   <= rpos_in;
         hpos_ff   <= hpos_in;
         count_ff  <= count_in;
         wopen_ff  <= wopen_in;
         ropen_ff  <= ropen_in;
         wrem_ff   <= wrem_in;
         rrem_ff   <= rrem_in;
         wmod_ff   <= wmod_in;
         rmod_ff   <= rmod_in;
         hash_ff   <= hash_in;
         rvalid_ff <= rvalid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      len_ff     <= len_in;
      byte_ff    <= byte_in;
      hdr_ff     <= hdr_in;
      dout_ff    <= dout_in;
      last_ff    <= last_in;
      err_ff     <= err_in;
      rstat_ff   <= rstat_in;
      rdata_ff   <= rdata_in;
      rlast_ff   <= rlast_in;
      rerr_ff    <= rerr_in;
      rqueued_ff <= rqueued_in;
   end

   assign rsp.valid           = rvalid_ff;
   assign rsp.status          = rstat_ff;
   assign rsp.data_out        = rdata_ff;
   assign rsp.last_byte       = rlast_ff;
   assign rsp.checksum_error  = rerr_ff;
   assign rsp.queued_messages = rqueued_ff;
endmodule

// ===== src/cmrq_ctrl.sv =====
// -----------------------------------------------------------------------------
// cmrq_ctrl
// Controller: decodes each request and sequences the datapath operations.
// -----------------------------------------------------------------------------
module cmrq_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  cmrq_pkg::cmrq_stat_type st,
   output cmrq_pkg::cmrq_ctl_type  ctl
);
   import cmrq_pkg::*;

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_DECODE   = 4'd1;
   localparam logic [3:0] S_HDR_WR   = 4'd2;
   localparam logic [3:0] S_HASH_HI  = 4'd3;
   localparam logic [3:0] S_HASH_LO  = 4'd4;
   localparam logic [3:0] S_HDR_RD   = 4'd5;
   localparam logic [3:0] S_HDR_CAP  = 4'd6;
   localparam logic [3:0] S_HDR_DONE = 4'd7;
   localparam logic [3:0] S_CHK      = 4'd8;
   localparam logic [3:0] S_BYTE_CAP = 4'd9;
   localparam logic [3:0] S_RESP     = 4'd10;

   logic [3:0] state_ff, state_in;
   logic [1:0] cnt_ff, cnt_in;
   logic [2:0] code_ff, code_in;

   assign req_ready = (state_ff == S_IDLE);

   // sequencing
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      code_in  = code_ff;
      ctl      = '{op: OP_NOP, idx: 2'd0, cap: 1'b0, code: code_ff};
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ctl.op   = OP_LATCH;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            code_in  = ST_IGNORED;
            state_in = S_RESP;
            case (st.cmd)
               CMD_BEGIN: begin
                  if (!st.writing_open && st.len_ok) begin
                     if (st.count_max || (!st.empty && !st.room_ok)) begin
                        code_in = ST_NO_ROOM;
                     end else begin
                        ctl.op   = OP_BEGIN;
                        code_in  = ST_BEGUN;
                        cnt_in   = 2'd0;
                        state_in = S_HDR_WR;
                     end
                  end
               end
               CMD_PAYLOAD: begin
                  if (st.writing_open) begin
                     ctl.op  = OP_PAY_WR;
                     code_in = ST_STORED;
                     if (st.wrem_one) state_in = S_HASH_HI;
                  end
               end
               CMD_POP: begin
                  if (st.reading_open) begin
                     ctl.op   = OP_BYTE_RD;
                     state_in = S_BYTE_CAP;
                  end else if (!st.empty) begin
                     ctl.op   = OP_HDR_RD;
                     ctl.idx  = 2'd0;
                     cnt_in   = 2'd1;
                     state_in = S_HDR_RD;
                  end else begin
                     code_in = ST_EMPTY;
                  end
               end
               default: code_in = ST_IGNORED;
            endcase
         end
         S_HDR_WR: begin
            ctl.op  = OP_HDR_WR;
            ctl.idx = cnt_ff;
            cnt_in  = cnt_ff + 2'd1;
            if (cnt_ff == 2'd3) state_in = S_RESP;
         end
         S_HASH_HI: begin
            ctl.op   = OP_HASH_WR;
            ctl.idx  = 2'd1;
            state_in = S_HASH_LO;
         end
         S_HASH_LO: begin
            ctl.op   = OP_HASH_WR;
            ctl.idx  = 2'd2;
            state_in = S_RESP;
         end
         S_HDR_RD: begin
            // next header byte read overlaps capture of the previous one
            ctl.op  = OP_HDR_RD;
            ctl.idx = cnt_ff;
            ctl.cap = 1'b1;
            cnt_in  = cnt_ff + 2'd1;
            if (cnt_ff == 2'd3) state_in = S_HDR_CAP;
         end
         S_HDR_CAP: begin
            ctl.cap  = 1'b1;
            state_in = S_HDR_DONE;
         end
         S_HDR_DONE: begin
            ctl.op   = OP_HDR_DONE;
            state_in = S_CHK;
         end
         S_CHK: begin
            if (st.reading_open) begin
               ctl.op   = OP_BYTE_RD;
               state_in = S_BYTE_CAP;
            end else begin
               code_in  = ST_EMPTY_MSG;
               state_in = S_RESP;
            end
         end
         S_BYTE_CAP: begin
            ctl.op   = OP_BYTE_CAP;
            code_in  = ST_BYTE;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (st.out_free) begin
               ctl.op   = OP_RESPOND;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= 2'd0;
         code_ff  <= ST_IGNORED;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         code_ff  <= code_in;
      end
   end
endmodule
